>>> sv/gradient_magnitude_from_normalized_pair_macros.svh
// Assertion macros shared by the checker of the gradient magnitude block.
// Expects clk and rst_n to be visible in the scope that uses them.
`ifndef GRADIENT_MAGNITUDE_FROM_NORMALIZED_PAIR_MACROS_SVH
`define GRADIENT_MAGNITUDE_FROM_NORMALIZED_PAIR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GMAG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define GMAG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/gmag_pkg.sv
// Shared types and constants for the gradient magnitude block.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package gmag_pkg;

    localparam int unsigned PIXEL_BITS = 8;
    localparam int unsigned PIXEL_FULL = 2**PIXEL_BITS - 1;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DATA_W     = 32;

    // Denormalise: x = p*(max-min) + offset keeps the dividend non-negative
    localparam int unsigned X_W      = 25;
    localparam int unsigned QE_W     = 18;
    localparam int unsigned Q_W      = 24;
    localparam int unsigned SQ_W     = 47;
    localparam int unsigned SUM_W    = 48;
    localparam int unsigned ROOT_W   = 32;
    localparam logic signed [25:0] DIV_OFFSET = 26'sd16777215;
    // (2^32 - 1) / 255, estimate of x/255 is low by at most one
    localparam logic [X_W-1:0]     DIV_RECIP  = 25'd16843009;
    // Offset plus offset/255, removed again when the Q.8 value is formed
    localparam logic signed [26:0] Q_BIAS     = 27'sd16843008;

    // Register map, one word apart
    typedef enum logic [2:0] {
        REG_HORIZ_MIN   = 3'd0,
        REG_HORIZ_MAX   = 3'd1,
        REG_VERT_MIN    = 3'd2,
        REG_VERT_MAX    = 3'd3,
        REG_KERNEL_MODE = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] horiz_min;
        logic [CFG_W-1:0] horiz_max;
        logic [CFG_W-1:0] vert_min;
        logic [CFG_W-1:0] vert_max;
        logic             kernel_mode;
    } cfg_t;

    // Side band through the first root unit
    typedef struct packed {
        logic mode;
        logic zero;
    } root_side_t;

    // Side band through the second root unit
    typedef struct packed {
        logic                  mode;
        logic                  zero;
        logic [PIXEL_BITS-1:0] mag_half;
    } quad_side_t;

endpackage

`default_nettype wire

>>> sv/gmag_cfg.sv
// APB-style register file holding the mapping ranges and the kernel mode.
// Depends on gmag_pkg for the register map and the cfg_t bundle.
`default_nettype none

module gmag_cfg
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gmag_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [gmag_pkg::DATA_W-1:0]   pwdata,
    output logic      [gmag_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output gmag_pkg::cfg_t                     cfg
);

    gmag_pkg::cfg_t       cfg_reg;
    gmag_pkg::cfg_t       cfg_next;
    gmag_pkg::reg_index_t index;
    logic                 write_en;

    assign pready   = 1'b1;
    assign index    = gmag_pkg::reg_index_t'(paddr[gmag_pkg::ADDR_W-1:2]);
    assign write_en = psel && penable && pwrite;

    // Update the addressed register on the access phase
    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (index)
                gmag_pkg::REG_HORIZ_MIN:   cfg_next.horiz_min   = pwdata[gmag_pkg::CFG_W-1:0];
                gmag_pkg::REG_HORIZ_MAX:   cfg_next.horiz_max   = pwdata[gmag_pkg::CFG_W-1:0];
                gmag_pkg::REG_VERT_MIN:    cfg_next.vert_min    = pwdata[gmag_pkg::CFG_W-1:0];
                gmag_pkg::REG_VERT_MAX:    cfg_next.vert_max    = pwdata[gmag_pkg::CFG_W-1:0];
                gmag_pkg::REG_KERNEL_MODE: cfg_next.kernel_mode = pwdata[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.horiz_min   <= '0;
            cfg_reg.horiz_max   <= gmag_pkg::CFG_W'(gmag_pkg::PIXEL_FULL);
            cfg_reg.vert_min    <= '0;
            cfg_reg.vert_max    <= gmag_pkg::CFG_W'(gmag_pkg::PIXEL_FULL);
            cfg_reg.kernel_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register, zero-extended
    always_comb
    begin
        prdata = '0;
        unique case (index)
            gmag_pkg::REG_HORIZ_MIN:   prdata = gmag_pkg::DATA_W'(cfg_reg.horiz_min);
            gmag_pkg::REG_HORIZ_MAX:   prdata = gmag_pkg::DATA_W'(cfg_reg.horiz_max);
            gmag_pkg::REG_VERT_MIN:    prdata = gmag_pkg::DATA_W'(cfg_reg.vert_min);
            gmag_pkg::REG_VERT_MAX:    prdata = gmag_pkg::DATA_W'(cfg_reg.vert_max);
            gmag_pkg::REG_KERNEL_MODE: prdata = gmag_pkg::DATA_W'(cfg_reg.kernel_mode);
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/gmag_scale.sv
// Seven-stage front end: denormalise both bytes to Q.8, square, sum and
// reduce to the radicand of the first root. Depends on gmag_pkg.
`default_nettype none

module gmag_scale
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire gmag_pkg::cfg_t                    cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [gmag_pkg::PIXEL_BITS-1:0]   horiz_pixel,
    input  wire logic [gmag_pkg::PIXEL_BITS-1:0]   vert_pixel,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [gmag_pkg::ROOT_W-1:0]       radicand,
    output gmag_pkg::root_side_t                   side
);

    localparam int unsigned STAGES = 7;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   adv;
    logic [STAGES-1:0] mode_reg;
    logic [STAGES-1:0] mode_next;

    // Stage 1: x = p*(max-min) + offset
    logic signed [16:0]             diff_h;
    logic signed [16:0]             diff_v;
    logic signed [25:0]             prod_h;
    logic signed [25:0]             prod_v;
    logic signed [25:0]             sum1_h;
    logic signed [25:0]             sum1_v;
    logic [gmag_pkg::X_W-1:0]       x1_h_reg, x1_h_next;
    logic [gmag_pkg::X_W-1:0]       x1_v_reg, x1_v_next;

    // Stage 2: reciprocal estimate of x/255
    logic [49:0]                    recip_h;
    logic [49:0]                    recip_v;
    logic [gmag_pkg::X_W-1:0]       x2_h_reg, x2_v_reg;
    logic [gmag_pkg::QE_W-1:0]      qe_h_reg, qe_h_next;
    logic [gmag_pkg::QE_W-1:0]      qe_v_reg, qe_v_next;

    // Stage 3: correct the estimate by one
    logic [25:0]                    back_h;
    logic [25:0]                    back_v;
    logic [25:0]                    rem_h;
    logic [25:0]                    rem_v;
    logic [gmag_pkg::X_W-1:0]       x3_h_reg, x3_v_reg;
    logic [gmag_pkg::QE_W-1:0]      fq_h_reg, fq_h_next;
    logic [gmag_pkg::QE_W-1:0]      fq_v_reg, fq_v_next;

    // Stage 4: signed Q.8 value
    logic signed [26:0]             q27_h;
    logic signed [26:0]             q27_v;
    logic signed [gmag_pkg::Q_W-1:0] q_h_reg, q_h_next;
    logic signed [gmag_pkg::Q_W-1:0] q_v_reg, q_v_next;

    // Stage 5: squares
    logic signed [47:0]             sqf_h;
    logic signed [47:0]             sqf_v;
    logic [gmag_pkg::SQ_W-1:0]      sq_h_reg, sq_h_next;
    logic [gmag_pkg::SQ_W-1:0]      sq_v_reg, sq_v_next;

    // Stage 6: Q.16 sum
    logic [gmag_pkg::SUM_W-1:0]     sum_reg, sum_next;

    // Stage 7: radicand floor((S-1)/2^16) and the zero flag
    logic [gmag_pkg::SUM_W-1:0]     sum_dec;
    logic [gmag_pkg::ROOT_W-1:0]    rad_reg, rad_next;
    logic                           zero_reg, zero_next;

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        adv[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = ~valid_reg[k] | adv[k+1];
        end
    end

    assign valid_next = {valid_reg[STAGES-2:0], in_valid};
    assign mode_next  = {mode_reg[STAGES-2:0], cfg.kernel_mode};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                mode_reg[k] <= mode_next[k];
            end
        end
    end

    // Stage 1
    assign diff_h = $signed({cfg.horiz_max[15], cfg.horiz_max})
                  - $signed({cfg.horiz_min[15], cfg.horiz_min});
    assign diff_v = $signed({cfg.vert_max[15], cfg.vert_max})
                  - $signed({cfg.vert_min[15], cfg.vert_min});
    assign prod_h = $signed({1'b0, horiz_pixel}) * diff_h;
    assign prod_v = $signed({1'b0, vert_pixel}) * diff_v;
    assign sum1_h = prod_h + gmag_pkg::DIV_OFFSET;
    assign sum1_v = prod_v + gmag_pkg::DIV_OFFSET;
    assign x1_h_next = sum1_h[gmag_pkg::X_W-1:0];
    assign x1_v_next = sum1_v[gmag_pkg::X_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x1_h_reg <= x1_h_next;
            x1_v_reg <= x1_v_next;
        end
    end

    // Stage 2
    assign recip_h   = 50'(x1_h_reg) * 50'(gmag_pkg::DIV_RECIP);
    assign recip_v   = 50'(x1_v_reg) * 50'(gmag_pkg::DIV_RECIP);
    assign qe_h_next = recip_h[49:32];
    assign qe_v_next = recip_v[49:32];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            x2_h_reg <= x1_h_reg;
            x2_v_reg <= x1_v_reg;
            qe_h_reg <= qe_h_next;
            qe_v_reg <= qe_v_next;
        end
    end

    // Stage 3
    assign back_h    = {qe_h_reg, 8'b0} - 26'(qe_h_reg);
    assign back_v    = {qe_v_reg, 8'b0} - 26'(qe_v_reg);
    assign rem_h     = 26'(x2_h_reg) - back_h;
    assign rem_v     = 26'(x2_v_reg) - back_v;
    assign fq_h_next = qe_h_reg + gmag_pkg::QE_W'(rem_h >= 26'(gmag_pkg::PIXEL_FULL));
    assign fq_v_next = qe_v_reg + gmag_pkg::QE_W'(rem_v >= 26'(gmag_pkg::PIXEL_FULL));

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            x3_h_reg <= x2_h_reg;
            x3_v_reg <= x2_v_reg;
            fq_h_reg <= fq_h_next;
            fq_v_reg <= fq_v_next;
        end
    end

    // Stage 4: q = 256*min + m + floor(m/255)
    assign q27_h = $signed({{3{cfg.horiz_min[15]}}, cfg.horiz_min, 8'b0})
                 + $signed({2'b0, x3_h_reg}) + $signed({9'b0, fq_h_reg}) - gmag_pkg::Q_BIAS;
    assign q27_v = $signed({{3{cfg.vert_min[15]}}, cfg.vert_min, 8'b0})
                 + $signed({2'b0, x3_v_reg}) + $signed({9'b0, fq_v_reg}) - gmag_pkg::Q_BIAS;
    assign q_h_next = q27_h[gmag_pkg::Q_W-1:0];
    assign q_v_next = q27_v[gmag_pkg::Q_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            q_h_reg <= q_h_next;
            q_v_reg <= q_v_next;
        end
    end

    // Stage 5
    assign sqf_h     = q_h_reg * q_h_reg;
    assign sqf_v     = q_v_reg * q_v_reg;
    assign sq_h_next = sqf_h[gmag_pkg::SQ_W-1:0];
    assign sq_v_next = sqf_v[gmag_pkg::SQ_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            sq_h_reg <= sq_h_next;
            sq_v_reg <= sq_v_next;
        end
    end

    // Stage 6
    assign sum_next = gmag_pkg::SUM_W'(sq_h_reg) + gmag_pkg::SUM_W'(sq_v_reg);

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            sum_reg <= sum_next;
        end
    end

    // Stage 7: ceil(S/2^16) - 1 equals floor((S-1)/2^16) for a non-zero sum
    assign sum_dec   = sum_reg - gmag_pkg::SUM_W'(1);
    assign rad_next  = sum_dec[gmag_pkg::SUM_W-1:16];
    assign zero_next = (sum_reg == '0);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            rad_reg  <= rad_next;
            zero_reg <= zero_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STAGES-1];
    assign radicand  = rad_reg;
    assign side.mode = mode_reg[STAGES-1];
    assign side.zero = zero_reg;

endmodule

`default_nettype wire

>>> sv/gmag_isqrt.sv
// Pipelined integer square root, one root bit per register stage, with a
// side band that travels alongside. Self-contained, no package use.
`default_nettype none

module gmag_isqrt
#(
    parameter int unsigned IN_W   = 32,
    parameter int unsigned SIDE_W = 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [IN_W-1:0]      radicand,
    input  wire logic [SIDE_W-1:0]    side_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [IN_W/2-1:0]    root,
    output logic      [SIDE_W-1:0]    side_out
);

    localparam int unsigned OUT_W = IN_W / 2;
    localparam int unsigned REM_W = OUT_W + 2;

    logic              valid_reg [OUT_W];
    logic              adv       [OUT_W+1];
    logic [IN_W-1:0]   rad_reg   [OUT_W];
    logic [REM_W-1:0]  rem_reg   [OUT_W];
    logic [OUT_W-1:0]  root_reg  [OUT_W];
    logic [SIDE_W-1:0] side_reg  [OUT_W];

    assign adv[OUT_W] = out_ready;

    for (genvar k = 0; k < OUT_W; k++)
    begin : g_step
        logic              valid_in;
        logic [IN_W-1:0]   rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [OUT_W-1:0]  root_in;
        logic [SIDE_W-1:0] side_in_k;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              fits;
        logic [REM_W-1:0]  rem_next;
        logic [OUT_W-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign valid_in  = in_valid;
            assign rad_in    = radicand;
            assign rem_in    = '0;
            assign root_in   = '0;
            assign side_in_k = side_in;
        end
        else
        begin : g_rest
            assign valid_in  = valid_reg[k-1];
            assign rad_in    = rad_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign root_in   = root_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        // Bring down the next two radicand bits and try 4*root + 1
        assign rem_sh    = {rem_in, rad_in[IN_W-1-2*k -: 2]};
        assign trial     = (REM_W+2)'({root_in, 2'b01});
        assign diff      = rem_sh - trial;
        assign fits      = (rem_sh >= trial);
        assign rem_next  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        assign root_next = {root_in[OUT_W-2:0], fits};

        assign adv[k] = ~valid_reg[k] | adv[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv[k])
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                rad_reg[k]  <= rad_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in_k;
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[OUT_W-1];
    assign root      = root_reg[OUT_W-1];
    assign side_out  = side_reg[OUT_W-1];

endmodule

`default_nettype wire

>>> sv/gradient_magnitude_from_normalized_pair.sv
// Top level of the gradient magnitude block: register file, front end,
// two root pipelines and the output register. Depends on gmag_pkg.
//
// Usage:
//   Pixel channel: pixel_valid/pixel_ready with horiz_pixel and vert_pixel,
//   one transfer per clock when the result side keeps up.
//   Result channel: result_valid/result_ready with magnitude (low 8 bits).
//   Configuration: APB-style writes at 4*index (horiz_min, horiz_max,
//   vert_min, vert_max, kernel_mode); pready is tied high. Change the
//   registers only while no pixel is in flight.
//   Depth: 7 front-end stages, 16 stages of the first square root (one
//   root bit each), 8 stages of the second root and the output register
//   lie between pixel transfer and result_valid. Throughput: one pixel per
//   cycle when the result side keeps up; the root pipelines set the depth, one bit per stage.
//   Stalls: each stage advances when empty or when its successor advances,
//   so bubbles close up and pixels keep entering while a result waits.
//   Up to 32 pixels are held before pixel_ready drops.
//   Reset: clears all valid bits and loads the register reset values
//   (ranges 0..255 on both axes, square-root mode).
`default_nettype none

module gradient_magnitude_from_normalized_pair
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gmag_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [gmag_pkg::DATA_W-1:0]       pwdata,
    output logic      [gmag_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready,
    input  wire logic                              pixel_valid,
    output logic                                   pixel_ready,
    input  wire logic [gmag_pkg::PIXEL_BITS-1:0]   horiz_pixel,
    input  wire logic [gmag_pkg::PIXEL_BITS-1:0]   vert_pixel,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic      [gmag_pkg::PIXEL_BITS-1:0]   magnitude
);

    localparam int unsigned ROOT1_W = gmag_pkg::ROOT_W / 2;
    localparam int unsigned ROOT2_W = ROOT1_W / 2;

    gmag_pkg::cfg_t          cfg;

    logic                        scale_valid;
    logic                        scale_ready;
    logic [gmag_pkg::ROOT_W-1:0] scale_rad;
    gmag_pkg::root_side_t        scale_side;

    logic                        sq1_valid;
    logic                        sq1_ready;
    logic [ROOT1_W-1:0]          sq1_root;
    logic [$bits(gmag_pkg::root_side_t)-1:0] sq1_side_bits;
    gmag_pkg::root_side_t        sq1_side;
    logic [ROOT1_W:0]            sq1_ceil;
    gmag_pkg::quad_side_t        sq2_side_in;

    logic                        sq2_valid;
    logic                        sq2_ready;
    logic [ROOT2_W-1:0]          sq2_root;
    logic [$bits(gmag_pkg::quad_side_t)-1:0] sq2_side_bits;
    gmag_pkg::quad_side_t        sq2_side;
    logic [ROOT2_W:0]            quad_ceil;
    logic [ROOT2_W+2:0]          quad_triple;

    logic                              out_valid_reg, out_valid_next;
    logic [gmag_pkg::PIXEL_BITS-1:0]   mag_reg, mag_next;
    logic                              out_adv;

    gmag_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gmag_scale u_scale
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (pixel_valid),
        .in_ready    (pixel_ready),
        .horiz_pixel (horiz_pixel),
        .vert_pixel  (vert_pixel),
        .out_valid   (scale_valid),
        .out_ready   (scale_ready),
        .radicand    (scale_rad),
        .side        (scale_side)
    );

    gmag_isqrt #(
        .IN_W   (gmag_pkg::ROOT_W),
        .SIDE_W ($bits(gmag_pkg::root_side_t))
    ) u_sqrt_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .radicand  (scale_rad),
        .side_in   (scale_side),
        .out_valid (sq1_valid),
        .out_ready (sq1_ready),
        .root      (sq1_root),
        .side_out  (sq1_side_bits)
    );

    // Square-root result r = floor root + 1; keep r/2 for the halving mode
    assign sq1_side             = gmag_pkg::root_side_t'(sq1_side_bits);
    assign sq1_ceil             = (ROOT1_W+1)'(sq1_root) + (ROOT1_W+1)'(1);
    assign sq2_side_in.mode     = sq1_side.mode;
    assign sq2_side_in.zero     = sq1_side.zero;
    assign sq2_side_in.mag_half = sq1_side.zero ? '0 : sq1_ceil[gmag_pkg::PIXEL_BITS:1];

    // Fourth root: smallest s with s*s >= r, i.e. the ceiling root of r
    gmag_isqrt #(
        .IN_W   (ROOT1_W),
        .SIDE_W ($bits(gmag_pkg::quad_side_t))
    ) u_sqrt_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq1_valid),
        .in_ready  (sq1_ready),
        .radicand  (sq1_root),
        .side_in   (sq2_side_in),
        .out_valid (sq2_valid),
        .out_ready (sq2_ready),
        .root      (sq2_root),
        .side_out  (sq2_side_bits)
    );

    // Pick the result for the selected kernel mode
    assign sq2_side    = gmag_pkg::quad_side_t'(sq2_side_bits);
    assign quad_ceil   = sq2_side.zero ? '0 : (ROOT2_W+1)'(sq2_root) + (ROOT2_W+1)'(1);
    assign quad_triple = {quad_ceil, 1'b0} + (ROOT2_W+3)'(quad_ceil);
    assign mag_next    = sq2_side.mode ? quad_triple[gmag_pkg::PIXEL_BITS-1:0]
                                       : sq2_side.mag_half;

    // Output register: load when empty or when the current result is taken
    assign out_adv        = ~out_valid_reg | result_ready;
    assign sq2_ready      = out_adv;
    assign out_valid_next = sq2_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            mag_reg <= mag_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign magnitude    = mag_reg;

endmodule

`default_nettype wire

>>> sv/gmag_checker.sv
// Port-level checker for the gradient magnitude block, bound to the top.
// Depends on gmag_pkg and the assertion macro header.
`default_nettype none

`include "gradient_magnitude_from_normalized_pair_macros.svh"

module gmag_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              psel,
    input wire logic                              penable,
    input wire logic                              pwrite,
    input wire logic [gmag_pkg::ADDR_W-1:0]       paddr,
    input wire logic [gmag_pkg::DATA_W-1:0]       pwdata,
    input wire logic [gmag_pkg::DATA_W-1:0]       prdata,
    input wire logic                              pready,
    input wire logic                              pixel_valid,
    input wire logic                              pixel_ready,
    input wire logic [gmag_pkg::PIXEL_BITS-1:0]   horiz_pixel,
    input wire logic [gmag_pkg::PIXEL_BITS-1:0]   vert_pixel,
    input wire logic                              result_valid,
    input wire logic                              result_ready,
    input wire logic [gmag_pkg::PIXEL_BITS-1:0]   magnitude
);

    // Pixels the block can hold: front end, both roots and output register
    localparam logic [5:0] Capacity = 6'd32;
    localparam logic [gmag_pkg::ADDR_W-1:0] ModeAddr = {gmag_pkg::REG_KERNEL_MODE, 2'b00};

    logic       pixel_xfer;
    logic       result_xfer;
    logic       mode_write;
    logic       mode_read;
    logic [5:0] count_reg, count_next;

    assign pixel_xfer  = pixel_valid && pixel_ready;
    assign result_xfer = result_valid && result_ready;
    assign mode_write  = psel && penable && pwrite && pready && (paddr == ModeAddr);
    assign mode_read   = psel && !pwrite && (paddr == ModeAddr);

    // Track pixels in flight
    assign count_next = count_reg + 6'(pixel_xfer) - 6'(result_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `GMAG_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(magnitude), "result changed while stalled")
    `GMAG_ASSERT_SAME(a_ready_follows, result_ready, pixel_ready, "pixel side stalled while result side is ready")
    `GMAG_ASSERT_SAME(a_no_phantom, result_xfer, count_reg != '0, "result transfer without a pixel in flight")
    `GMAG_ASSERT_SAME(a_capacity, pixel_xfer && !result_xfer, count_reg < Capacity, "pixel taken beyond pipeline capacity")
    `GMAG_ASSERT_SAME(a_mode_readback, mode_read && $past(mode_write) && $past(rst_n), prdata == gmag_pkg::DATA_W'($past(pwdata[0])), "kernel mode readback mismatch")

endmodule

bind gradient_magnitude_from_normalized_pair gmag_checker u_gmag_checker (.*);

`default_nettype wire
